>>> src/q24a_pkg.sv
`timescale 1ns / 1ps

package q24a_pkg;

  // Word geometry of the signed Q24.8 format.
  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int FUNC_W    = 4;
  localparam int PROD_W    = 2 * WORD_W;
  // The scaled dividend |a| * 2^FRAC_BITS, one quotient bit per divider stage.
  localparam int DVD_W     = WORD_W + FRAC_BITS;

  // Padded stream word widths.
  localparam int IN_DATA_W  = ((FUNC_W + 2 * WORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WORD_W + 1 + 7) / 8) * 8;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_TO_INT   = 4'd14,
    FN_FROM_INT = 4'd15
  } func_t;

  // Everything an item carries down the divider chain.
  typedef struct packed {
    logic [WORD_W-1:0] rem;      // partial remainder
    logic [DVD_W-1:0]  dvd;      // dividend bits still to be brought down
    logic [WORD_W-1:0] dvs;      // divisor magnitude
    logic [WORD_W-1:0] quo;      // quotient bits so far, wrapped to a word
    logic              neg;      // quotient is negative
    logic              dvs_zero; // division by zero
    logic              is_div;   // item is a divide
    logic [WORD_W-1:0] res;      // result of any other operation
    logic              flag;     // compare outcome of any other operation
  } work_t;

endpackage

>>> src/q24_8_fixed_point_alu.sv
`timescale 1ns / 1ps
// Every operation takes the same path from an accepted input word to out_tvalid: pre, divider chain, post, output.
// Throughput: one word per cycle; the divide runs as 40 one-bit restoring stages in line.
// A stalled output is caught by a skid register; the pipeline holds only once that is full.
// Reset: synchronous, active low; it empties the pipeline, skid and output, no clearing pass.

module q24_8_fixed_point_alu
  import q24a_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // func [3:0], operand_a [35:4], operand_b [67:36], zero padding above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result_value [31:0], flag [32], zero padding above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic              en;
  logic              pre_valid;
  work_t             pre_work;
  logic              step_valid [DVD_W+1];
  work_t             step_work  [DVD_W+1];
  logic              post_valid;
  logic [WORD_W-1:0] post_value;
  logic              post_flag;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_value_r;
  logic              out_flag_r;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  logic [WORD_W-1:0] skid_value_r;
  logic              skid_flag_r;
  logic              load_out;
  logic              load_skid;
  logic              out_from_skid;

  // The whole pipeline moves while the skid register is free.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  q24a_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_func   (in_tdata[FUNC_W-1:0]),
    .in_a      (in_tdata[FUNC_W +: WORD_W]),
    .in_b      (in_tdata[FUNC_W+WORD_W +: WORD_W]),
    .out_valid (pre_valid),
    .out_work  (pre_work)
  );

  assign step_valid[0] = pre_valid;
  assign step_work[0]  = pre_work;

  // Divider chain, one quotient bit per stage.
  for (genvar i = 0; i < DVD_W; i++) begin : g_div
    q24a_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (step_valid[i]),
      .in_work   (step_work[i]),
      .out_valid (step_valid[i+1]),
      .out_work  (step_work[i+1])
    );
  end

  q24a_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (step_valid[DVD_W]),
    .in_work   (step_work[DVD_W]),
    .out_valid (post_valid),
    .out_value (post_value),
    .out_flag  (post_flag)
  );

  // Output register with skid: the skid word drains first.
  always_comb begin
    out_from_skid  = skid_valid_r && out_tready;
    load_out       = !skid_valid_r && (!out_valid_r || out_tready);
    load_skid      = !skid_valid_r && out_valid_r && !out_tready && post_valid;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_from_skid) begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end else if (load_out) begin
      out_valid_nxt = post_valid;
    end else if (load_skid) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_value_r <= skid_value_r;
      out_flag_r  <= skid_flag_r;
    end else if (load_out) begin
      out_value_r <= post_value;
      out_flag_r  <= post_flag;
    end
    if (load_skid) begin
      skid_value_r <= post_value;
      skid_flag_r  <= post_flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-WORD_W-1){1'b0}}, out_flag_r, out_value_r};

endmodule

>>> src/q24a_pre.sv
`timescale 1ns / 1ps

module q24a_pre
  import q24a_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [WORD_W-1:0]  in_a,
  input  logic [WORD_W-1:0]  in_b,
  output logic               out_valid,
  output work_t              out_work
);

  logic signed [WORD_W-1:0] a_s;
  logic signed [WORD_W-1:0] b_s;
  logic                     a_lt_b;
  logic                     a_eq_b;
  logic [WORD_W-1:0]        mag_a;
  logic [WORD_W-1:0]        mag_b;
  logic [WORD_W-1:0]        int_mag;
  func_t                    func;

  logic                     valid_r;
  work_t                    work_r;
  work_t                    work_nxt;
  logic                     is_mul_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // Operand decode and magnitudes.
  always_comb begin
    a_s     = $signed(in_a);
    b_s     = $signed(in_b);
    a_lt_b  = a_s < b_s;
    a_eq_b  = in_a == in_b;
    mag_a   = in_a[WORD_W-1] ? (~in_a + 1'b1) : in_a;
    mag_b   = in_b[WORD_W-1] ? (~in_b + 1'b1) : in_b;
    int_mag = mag_a >> FRAC_BITS;
    func    = func_t'(in_func);
    prod_nxt = a_s * b_s;
  end

  // Results of the operations other than divide and multiply, and set-up of the divider.
  always_comb begin
    work_nxt          = '0;
    work_nxt.dvd      = {mag_a, {FRAC_BITS{1'b0}}};
    work_nxt.dvs      = mag_b;
    work_nxt.neg      = in_a[WORD_W-1] ^ in_b[WORD_W-1];
    work_nxt.dvs_zero = in_b == '0;
    work_nxt.is_div   = func == FN_DIV;
    unique case (func)
      FN_ADD:      work_nxt.res = in_a + in_b;
      FN_SUB:      work_nxt.res = in_a - in_b;
      FN_GT:       work_nxt.flag = !a_lt_b && !a_eq_b;
      FN_LT:       work_nxt.flag = a_lt_b;
      FN_GE:       work_nxt.flag = !a_lt_b;
      FN_LE:       work_nxt.flag = a_lt_b || a_eq_b;
      FN_EQ:       work_nxt.flag = a_eq_b;
      FN_NE:       work_nxt.flag = !a_eq_b;
      FN_MIN:      work_nxt.res = (a_lt_b || a_eq_b) ? in_a : in_b;
      FN_MAX:      work_nxt.res = !a_lt_b ? in_a : in_b;
      FN_INC:      work_nxt.res = in_a + 1'b1;
      FN_DEC:      work_nxt.res = in_a - 1'b1;
      FN_TO_INT:   work_nxt.res = in_a[WORD_W-1] ? (~int_mag + 1'b1) : int_mag;
      FN_FROM_INT: work_nxt.res = in_a << FRAC_BITS;
      default:     work_nxt.res = '0;
    endcase
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload, including the full product.
  always_ff @(posedge clk) begin
    if (en) begin
      work_r   <= work_nxt;
      is_mul_r <= func == FN_MUL;
      prod_r   <= prod_nxt;
    end
  end

  // The product shifted down by the fraction width, wrapped to one word.
  always_comb begin
    out_work = work_r;
    if (is_mul_r) begin
      out_work.res = prod_r[FRAC_BITS +: WORD_W];
    end
  end

  assign out_valid = valid_r;

endmodule

>>> src/q24a_div_step.sv
`timescale 1ns / 1ps

module q24a_div_step
  import q24a_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  work_t in_work,
  output logic  out_valid,
  output work_t out_work
);

  logic [WORD_W+1:0] diff;
  logic              take;
  logic              valid_r;
  work_t             work_r;
  work_t             work_nxt;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    diff     = {1'b0, in_work.rem, in_work.dvd[DVD_W-1]} - {2'b00, in_work.dvs};
    take     = !diff[WORD_W+1];
    work_nxt = in_work;
    work_nxt.rem = take ? diff[WORD_W-1:0]
                        : {in_work.rem[WORD_W-2:0], in_work.dvd[DVD_W-1]};
    work_nxt.dvd = {in_work.dvd[DVD_W-2:0], 1'b0};
    work_nxt.quo = {in_work.quo[WORD_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

>>> src/q24a_post.sv
`timescale 1ns / 1ps

module q24a_post
  import q24a_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  work_t             in_work,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_value,
  output logic              out_flag
);

  logic              valid_r;
  logic [WORD_W-1:0] value_r;
  logic [WORD_W-1:0] value_nxt;
  logic              flag_r;
  logic              flag_nxt;

  // Sign the quotient, force zero on division by zero, else pass the result.
  always_comb begin
    if (!in_work.is_div) begin
      value_nxt = in_work.res;
      flag_nxt  = in_work.flag;
    end else if (in_work.dvs_zero) begin
      value_nxt = '0;
      flag_nxt  = 1'b1;
    end else begin
      value_nxt = in_work.neg ? (~in_work.quo + 1'b1) : in_work.quo;
      flag_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_flag  = flag_r;

endmodule
